@@ design/scx_pkg.sv @@
`default_nettype none
package scx_pkg;

  // default coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // fraction bits of the segment parameter t
  localparam int unsigned T_BITS = 16;

  // rounding offset for the point product
  localparam int unsigned T_HALF = 1 << (T_BITS - 1);

endpackage
`default_nettype wire

@@ design/scx_front.sv @@
`default_nettype none
module scx_front #(
  parameter int unsigned W = scx_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic signed [W-1:0]    circle_x_i,
  input  wire logic signed [W-1:0]    circle_y_i,
  input  wire logic        [W-2:0]    radius_i,
  input  wire logic signed [W-1:0]    start_x_i,
  input  wire logic signed [W-1:0]    start_y_i,
  input  wire logic signed [W-1:0]    end_x_i,
  input  wire logic signed [W-1:0]    end_y_i,
  output logic                        valid_o,
  output logic                        ok_o,
  output logic [4*(W+1)-1:0]          disc_o,
  output logic signed [2*(W+1)-1:0]   h_o,
  output logic [2*(W+1)-1:0]          a_o,
  output logic signed [W-1:0]         sx_o,
  output logic signed [W-1:0]         sy_o,
  output logic signed [W:0]           dx_o,
  output logic signed [W:0]           dy_o
);

  localparam int unsigned N  = W + 1;
  localparam int unsigned N2 = 2 * N;
  localparam int unsigned DW = 4 * N;
  localparam int unsigned NS = 6;

  // valid bits of the six stages
  logic [NS-1:0] valid_q;

  // passed-through coordinates, one set per stage
  logic signed [W-1:0] sx_q [NS];
  logic signed [W-1:0] sy_q [NS];
  logic signed [N-1:0] dx_q [NS];
  logic signed [N-1:0] dy_q [NS];

  // stage 1: differences
  logic signed [N-1:0] fx_q, fy_q;
  logic [W-2:0]        r_q;

  // stage 2: coordinate products
  logic signed [N2-1:0] dxx_q, dyy_q, fdx_q, fdy_q, fxx_q, fyy_q;
  logic [2*W-3:0]       rr_q;

  // stage 3: quadratic coefficients
  logic [N2-1:0]        a3_q;
  logic signed [N2-1:0] h3_q, c3_q;

  // stage 4: partial products of h*h and a*c
  logic signed [N2-1:0] pp_hh_q;
  logic signed [N2:0]   pp_hl_q;
  logic [N2-1:0]        pp_ll_q;
  logic signed [N2:0]   pp_ahch_q, pp_alch_q;
  logic [N2-1:0]        pp_ahcl_q, pp_alcl_q;
  logic [N2-1:0]        a4_q;
  logic signed [N2-1:0] h4_q;

  // stage 5: h*h and a*c
  logic signed [DW-1:0] hsq_q, ac_q;
  logic [N2-1:0]        a5_q;
  logic signed [N2-1:0] h5_q;

  // stage 6: discriminant
  logic signed [DW-1:0] disc_q;
  logic [N2-1:0]        a6_q;
  logic signed [N2-1:0] h6_q;
  logic                 ok_q;

  logic signed [N-1:0] hh, ch;
  logic [N-1:0]        hl, ah, al, cl;
  logic signed [DW-1:0] hsq_d, ac_d, disc_d;

  // operand split for the wide products
  always_comb begin
    hh = h3_q[N2-1:N];
    hl = h3_q[N-1:0];
    ch = c3_q[N2-1:N];
    cl = c3_q[N-1:0];
    ah = a3_q[N2-1:N];
    al = a3_q[N-1:0];
  end

  // partial product sums
  always_comb begin
    hsq_d = (DW'(pp_hh_q) <<< N2) + (DW'(pp_hl_q) <<< (N + 1))
          + $signed(DW'(pp_ll_q));
    ac_d  = (DW'(pp_ahch_q) <<< N2)
          + ((DW'(pp_alch_q) + $signed(DW'(pp_ahcl_q))) <<< N)
          + $signed(DW'(pp_alcl_q));
    disc_d = hsq_q - ac_q;
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0] <= start_x_i;
      sy_q[0] <= start_y_i;
      dx_q[0] <= N'(end_x_i) - N'(start_x_i);
      dy_q[0] <= N'(end_y_i) - N'(start_y_i);
      fx_q    <= N'(start_x_i) - N'(circle_x_i);
      fy_q    <= N'(start_y_i) - N'(circle_y_i);
      r_q     <= radius_i;
      for (int k = 1; k < NS; k++) begin
        sx_q[k] <= sx_q[k-1];
        sy_q[k] <= sy_q[k-1];
        dx_q[k] <= dx_q[k-1];
        dy_q[k] <= dy_q[k-1];
      end

      dxx_q <= dx_q[0] * dx_q[0];
      dyy_q <= dy_q[0] * dy_q[0];
      fdx_q <= fx_q * dx_q[0];
      fdy_q <= fy_q * dy_q[0];
      fxx_q <= fx_q * fx_q;
      fyy_q <= fy_q * fy_q;
      rr_q  <= r_q * r_q;

      a3_q <= N2'(dxx_q + dyy_q);
      h3_q <= fdx_q + fdy_q;
      c3_q <= fxx_q + fyy_q - $signed(N2'(rr_q));

      pp_hh_q   <= hh * hh;
      pp_hl_q   <= hh * $signed({1'b0, hl});
      pp_ll_q   <= hl * hl;
      pp_ahch_q <= $signed({1'b0, ah}) * ch;
      pp_alch_q <= $signed({1'b0, al}) * ch;
      pp_ahcl_q <= ah * cl;
      pp_alcl_q <= al * cl;
      a4_q      <= a3_q;
      h4_q      <= h3_q;

      hsq_q <= hsq_d;
      ac_q  <= ac_d;
      a5_q  <= a4_q;
      h5_q  <= h4_q;

      disc_q <= disc_d;
      ok_q   <= (a5_q != '0) && !disc_d[DW-1];
      a6_q   <= a5_q;
      h6_q   <= h5_q;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign ok_o    = ok_q;
  assign disc_o  = disc_q;
  assign h_o     = h6_q;
  assign a_o     = a6_q;
  assign sx_o    = sx_q[NS-1];
  assign sy_o    = sy_q[NS-1];
  assign dx_o    = dx_q[NS-1];
  assign dy_o    = dy_q[NS-1];

endmodule
`default_nettype wire

@@ design/scx_sqrt.sv @@
`default_nettype none
module scx_sqrt #(
  parameter int unsigned RW  = 34,
  parameter int unsigned SBW = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [2*RW-1:0]   rad_i,
  input  wire logic [SBW-1:0]    sb_i,
  output logic                   valid_o,
  output logic [RW-1:0]          root_o,
  output logic [SBW-1:0]         sb_o
);

  localparam int unsigned RMW = RW + 3;

  // one result bit per stage
  logic              valid_q [RW];
  logic [RMW-1:0]    rem_q   [RW];
  logic [RW-1:0]     root_q  [RW];
  logic [2*RW-1:0]   rest_q  [RW];
  logic [SBW-1:0]    sb_q    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           v_in;
    logic [RMW-1:0] rem_in, rem_sh, trial;
    logic [RW-1:0]  root_in;
    logic [2*RW-1:0] rest_in;
    logic [SBW-1:0] sb_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = rad_i;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rest_in = rest_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // bring down two radicand bits and try root*4+1
    always_comb begin
      rem_sh = {rem_in[RMW-3:0], rest_in[2*RW-1 -: 2]};
      trial  = RMW'({root_in, 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
        rest_q[k] <= rest_in << 2;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule
`default_nettype wire

@@ design/scx_div.sv @@
`default_nettype none
module scx_div #(
  parameter int unsigned AW  = 34,
  parameter int unsigned SBW = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [AW-1:0]               num_i,
  input  wire logic [AW-1:0]               den_i,
  input  wire logic [SBW-1:0]              sb_i,
  output logic                             valid_o,
  output logic [scx_pkg::T_BITS:0]         quo_o,
  output logic [SBW-1:0]                   sb_o
);

  localparam int unsigned QB  = scx_pkg::T_BITS + 1;
  localparam int unsigned RMW = AW + 1;

  // one quotient bit per stage, num <= den so the top bit is num == den
  logic            valid_q [QB];
  logic [RMW-1:0]  rem_q   [QB];
  logic [AW-1:0]   den_q   [QB];
  logic [QB-1:0]   quo_q   [QB];
  logic [SBW-1:0]  sb_q    [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic           v_in;
    logic [RMW-1:0] rem_x;
    logic [AW-1:0]  den_in;
    logic [QB-1:0]  quo_in;
    logic [SBW-1:0] sb_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_x  = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign rem_x  = {rem_q[k-1][RMW-2:0], 1'b0};
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign ge = rem_x >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_x - {1'b0, den_in} : rem_x;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QB-2:0], ge};
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = valid_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign sb_o    = sb_q[QB-1];

endmodule
`default_nettype wire

@@ design/segment_circle_intersection.sv @@
// throughput: one request per cycle while no held result stalls; set by the one-bit-per-stage square root
// and divider pipelines, every stage advances together
// a stalled result holds the whole pipeline and raises in_stall_o
// reset (rst_ni low, asynchronous) clears all valid bits; no other state
`default_nettype none
module segment_circle_intersection #(
  parameter int unsigned COORD_WIDTH = scx_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0]  circle_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  circle_y_i,
  input  wire logic        [COORD_WIDTH-2:0]  radius_i,
  input  wire logic signed [COORD_WIDTH-1:0]  start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]  end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  end_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                hit_o,
  output logic signed [COORD_WIDTH-1:0]       point_x_o,
  output logic signed [COORD_WIDTH-1:0]       point_y_o,
  output logic [scx_pkg::T_BITS:0]            param_t_o,
  output logic                                far_root_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned N    = W + 1;
  localparam int unsigned N2   = 2 * N;
  localparam int unsigned NW   = N2 + 2;
  localparam int unsigned TB   = scx_pkg::T_BITS;
  localparam int unsigned QB   = TB + 1;
  localparam int unsigned PW   = N + QB + 2;
  localparam int unsigned SB1W = 2 * W + 2 * N + 2 * N2 + 1;
  localparam int unsigned SB2W = 2 * W + 2 * N + 2;

  logic en;

  // whole pipeline advances unless a finished result is held
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // front end: coefficients and discriminant
  logic                 f_valid, f_ok;
  logic [4*N-1:0]       f_disc;
  logic signed [N2-1:0] f_h;
  logic [N2-1:0]        f_a;
  logic signed [W-1:0]  f_sx, f_sy;
  logic signed [N-1:0]  f_dx, f_dy;

  scx_front #(.W(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .circle_x_i (circle_x_i),
    .circle_y_i (circle_y_i),
    .radius_i   (radius_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .valid_o    (f_valid),
    .ok_o       (f_ok),
    .disc_o     (f_disc),
    .h_o        (f_h),
    .a_o        (f_a),
    .sx_o       (f_sx),
    .sy_o       (f_sy),
    .dx_o       (f_dx),
    .dy_o       (f_dy)
  );

  // square root of the discriminant
  logic            s_valid;
  logic [N2-1:0]   s_root;
  logic [SB1W-1:0] s_sb;

  scx_sqrt #(.RW(N2), .SBW(SB1W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rad_i   (f_disc),
    .sb_i    ({f_ok, f_h, f_a, f_sx, f_sy, f_dx, f_dy}),
    .valid_o (s_valid),
    .root_o  (s_root),
    .sb_o    (s_sb)
  );

  logic                 s_ok;
  logic signed [N2-1:0] s_h;
  logic [N2-1:0]        s_a;
  logic signed [W-1:0]  s_sx, s_sy;
  logic signed [N-1:0]  s_dx, s_dy;
  logic signed [NW-1:0] n_near, n_far, a_ext;
  logic                 hit_near, hit_far;

  assign {s_ok, s_h, s_a, s_sx, s_sy, s_dx, s_dy} = s_sb;

  // root numerators and range test 0 <= n <= a, nearer root first
  always_comb begin
    a_ext    = $signed({2'b00, s_a});
    n_near   = -NW'(s_h) - $signed({2'b00, s_root});
    n_far    = -NW'(s_h) + $signed({2'b00, s_root});
    hit_near = s_ok && !n_near[NW-1] && (n_near <= a_ext);
    hit_far  = s_ok && !n_far[NW-1] && (n_far <= a_ext);
  end

  logic                sel_valid_q;
  logic                sel_hit_q, sel_far_q;
  logic [N2-1:0]       sel_num_q, sel_den_q;
  logic signed [W-1:0] sel_sx_q, sel_sy_q;
  logic signed [N-1:0] sel_dx_q, sel_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (en) begin
      sel_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_hit_q <= hit_near || hit_far;
      sel_far_q <= !hit_near && hit_far;
      sel_num_q <= hit_near ? n_near[N2-1:0] : n_far[N2-1:0];
      sel_den_q <= s_a;
      sel_sx_q  <= s_sx;
      sel_sy_q  <= s_sy;
      sel_dx_q  <= s_dx;
      sel_dy_q  <= s_dy;
    end
  end

  // t = floor(n * 2^T_BITS / a)
  logic            d_valid;
  logic [QB-1:0]   d_quo;
  logic [SB2W-1:0] d_sb;

  scx_div #(.AW(N2), .SBW(SB2W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sel_valid_q),
    .num_i   (sel_num_q),
    .den_i   (sel_den_q),
    .sb_i    ({sel_hit_q, sel_far_q, sel_sx_q, sel_sy_q, sel_dx_q, sel_dy_q}),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .sb_o    (d_sb)
  );

  logic                d_hit, d_far;
  logic signed [W-1:0] d_sx, d_sy;
  logic signed [N-1:0] d_dx, d_dy;

  assign {d_hit, d_far, d_sx, d_sy, d_dx, d_dy} = d_sb;

  // d * t products
  logic                   mul_valid_q;
  logic                   mul_hit_q, mul_far_q;
  logic [QB-1:0]          mul_t_q;
  logic signed [W-1:0]    mul_sx_q, mul_sy_q;
  logic signed [N+QB:0]   mul_px_q, mul_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_hit_q <= d_hit;
      mul_far_q <= d_far;
      mul_t_q   <= d_quo;
      mul_sx_q  <= d_sx;
      mul_sy_q  <= d_sy;
      mul_px_q  <= d_dx * $signed({1'b0, d_quo});
      mul_py_q  <= d_dy * $signed({1'b0, d_quo});
    end
  end

  // rounded offset added to the start point
  logic signed [PW-1:0] rnd_x, rnd_y;

  always_comb begin
    rnd_x = (PW'(mul_px_q) + $signed(PW'(scx_pkg::T_HALF))) >>> TB;
    rnd_y = (PW'(mul_py_q) + $signed(PW'(scx_pkg::T_HALF))) >>> TB;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o      <= mul_hit_q;
      far_root_o <= mul_hit_q && mul_far_q;
      param_t_o  <= mul_hit_q ? mul_t_q : '0;
      point_x_o  <= mul_hit_q ? mul_sx_q + rnd_x[W-1:0] : '0;
      point_y_o  <= mul_hit_q ? mul_sy_q + rnd_y[W-1:0] : '0;
    end
  end

endmodule
`default_nettype wire
